/* design/prt_pkg.sv */
// package for the primitive root tester
// holds the sequencer state type and the result status codes; no dependencies
package prt_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_TOO_SMALL    = 2'd1;
  localparam status_t ST_NOT_PRIME    = 2'd2;
  localparam status_t ST_OUT_OF_RANGE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SQ,
    S_SQCHK,
    S_DIV,
    S_RNG,
    S_LOOP,
    S_MUL,
    S_RSTART,
    S_RWAIT
  } state_t;

endpackage

/* design/prt_rem.sv */
// shared remainder unit, restoring shift-subtract, one quotient bit per cycle
// reduces {hi, lo} modulo div where hi < div; no package dependencies
module prt_rem #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] hi,
  input  logic [W-1:0] lo,
  input  logic [W-1:0] div,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  low;
  logic [W-1:0]  dv;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, low[W-1]};
  assign diff  = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // no borrow out of the subtract means trial >= dv
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi;
      low <= lo;
      dv  <= div;
    end else if (run) begin
      low <= {low[W-2:0], 1'b0};
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= trial[W-1:0];
      end
    end
  end

  assign res = rem;

endmodule

/* design/primitive_root_tester.sv */
// primitive root tester: modulus check by trial division, then power walk mod p
// sequence: a too small modulus or an even one other than two is rejected by the first check;
// otherwise one trial division per odd divisor up to sqrt(modulus), then up to modulus-2
// power steps, each paced by the shared one-bit-a-cycle remainder unit
// throughput: one request at a time, busy stays high until the result strobe
// reset: synchronous, clears modulus and control; results are taken as strobed
module primitive_root_tester #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel for the modulus register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VALUE_WIDTH-1:0] cfg_data,
  // request side
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] candidate,
  // result side, one cycle strobe
  output logic                   done,
  output logic                   is_root,
  output prt_pkg::status_t       status
);
  import prt_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * VALUE_WIDTH;

  state_t        state;
  state_t        state_next;

  logic [W-1:0]  modulus;   // configured p
  logic [W-1:0]  a;         // latched candidate
  logic [W-1:0]  pw;        // current power a^i mod p
  logic [W-1:0]  i;         // exponent counter
  logic [W-1:0]  d;         // odd trial divisor
  logic [PW-1:0] prod;      // registered multiplier output

  // shared multiplier operand select
  logic [W-1:0]  op_x;
  logic [W-1:0]  op_y;

  // remainder unit hookup
  logic          rem_start;
  logic [W-1:0]  rem_hi;
  logic [W-1:0]  rem_lo;
  logic [W-1:0]  rem_div;
  logic          rem_done;
  logic [W-1:0]  rem_res;

  // finishing controls
  logic          fin;
  logic          fin_root;
  status_t       fin_status;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  prt_rem #(.W(W)) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .hi    (rem_hi),
    .lo    (rem_lo),
    .div   (rem_div),
    .done  (rem_done),
    .res   (rem_res)
  );

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= '0;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  // result payload, held until the next finish
  always_ff @(posedge clk) begin
    if (fin) begin
      is_root <= fin_root;
      status  <= fin_status;
    end
  end

  // datapath registers driven by the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          a <= candidate;
        end
      end
      S_CHK: begin
        d <= W'(3);
      end
      S_SQ, S_MUL: begin
        // one shared W x W multiply, registered before any use
        prod <= PW'(op_x) * PW'(op_y);
      end
      S_DIV: begin
        if (rem_done) begin
          d <= d + W'(2);
        end
      end
      S_RNG: begin
        pw <= a;
        i  <= W'(1);
      end
      S_RWAIT: begin
        if (rem_done) begin
          pw <= rem_res;
          i  <= i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_root   = 1'b0;
    fin_status = ST_OK;
    rem_start  = 1'b0;
    rem_hi     = '0;
    rem_lo     = modulus;
    rem_div    = d;
    op_x       = pw;
    op_y       = a;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHK;
        end
      end
      // quick modulus checks: too small, two, even
      S_CHK: begin
        if (modulus <= W'(1)) begin
          fin        = 1'b1;
          fin_status = ST_TOO_SMALL;
          state_next = S_IDLE;
        end else if (modulus == W'(2)) begin
          state_next = S_RNG;
        end else if (!modulus[0]) begin
          fin        = 1'b1;
          fin_status = ST_NOT_PRIME;
          state_next = S_IDLE;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        op_x       = d;
        op_y       = d;
        state_next = S_SQCHK;
      end
      // divisor squared past p means no factor left, so p is prime
      S_SQCHK: begin
        if (prod > PW'(modulus)) begin
          state_next = S_RNG;
        end else begin
          rem_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          if (rem_res == '0) begin
            fin        = 1'b1;
            fin_status = ST_NOT_PRIME;
            state_next = S_IDLE;
          end else begin
            state_next = S_SQ;
          end
        end
      end
      S_RNG: begin
        if (a == '0 || a >= modulus) begin
          fin        = 1'b1;
          fin_status = ST_OUT_OF_RANGE;
          state_next = S_IDLE;
        end else begin
          state_next = S_LOOP;
        end
      end
      // walk exponents 1 .. p-2, stop at the first power equal to one
      S_LOOP: begin
        if (i >= modulus - 1'b1) begin
          fin        = 1'b1;
          fin_root   = 1'b1;
          state_next = S_IDLE;
        end else if (pw == W'(1)) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_RSTART;
      end
      // product < p*p, so its upper half is already below p
      S_RSTART: begin
        rem_start  = 1'b1;
        rem_hi     = prod[PW-1:W];
        rem_lo     = prod[W-1:0];
        rem_div    = modulus;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        if (rem_done) begin
          state_next = S_LOOP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* bench/root_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the primitive root tester: watches the modulus writes,
// the requests and the result strobe, predicts each verdict and compares it
// depends on prt_pkg for the status codes
module root_result_checker #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [VALUE_WIDTH-1:0] cfg_data,
  input  logic                   start,
  input  logic                   busy,
  input  logic [VALUE_WIDTH-1:0] candidate,
  input  logic                   done,
  input  logic                   is_root,
  input  prt_pkg::status_t       status,
  output int                     errors,
  output int                     outstanding
);
  import prt_pkg::*;

  typedef struct packed {
    logic    is_root;
    status_t status;
  } verdict_t;

  verdict_t               pending_verdicts[$];
  logic [VALUE_WIDTH-1:0] modulus_copy;

  function automatic bit modulus_prime(longint unsigned n);
    longint unsigned d;
    if (n == 2) return 1'b1;
    if (n < 2 || n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // walk the powers a^1 .. a^(p-2); a hit on 1 means the order is too short
  function automatic bit full_order(longint unsigned a, longint unsigned p);
    longint unsigned power;
    longint unsigned step;
    power = a % p;
    for (step = 1; step + 1 < p; step++) begin
      if (power == 1) return 1'b0;
      power = (power * a) % p;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t root_verdict(logic [VALUE_WIDTH-1:0] a,
                                            logic [VALUE_WIDTH-1:0] p);
    verdict_t v;
    v.is_root = 1'b0;
    if (p <= 1)
      v.status = ST_TOO_SMALL;
    else if (!modulus_prime(p))
      v.status = ST_NOT_PRIME;
    else if (a == 0 || a >= p)
      v.status = ST_OUT_OF_RANGE;
    else begin
      v.status  = ST_OK;
      v.is_root = full_order(a, p);
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    if (rst) begin
      modulus_copy = '0;
      pending_verdicts.delete();
      errors = 0;
    end else begin
      if (done) begin
        got.is_root = is_root;
        got.status  = status;
        if (pending_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no request waiting: is_root %0b status %0d",
                     $realtime, got.is_root, got.status);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.is_root !== want.is_root || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected is_root %0b status %0d, got is_root %0b status %0d",
                       $realtime, want.is_root, want.status, got.is_root, got.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) modulus_copy = cfg_data;
      if (start && !busy) pending_verdicts.push_back(root_verdict(candidate, modulus_copy));
    end
    outstanding = pending_verdicts.size();
  end

endmodule

/* bench/tb_primitive_root_tester.sv */
`timescale 1ns / 100ps
// testbench top for the primitive root tester: drives modulus writes and
// candidate requests, and gives the verdict from the result checker
// depends on prt_pkg, primitive_root_tester and root_result_checker
module tb_primitive_root_tester;
  import prt_pkg::*;

  localparam int W = 16;
  // largest 16-bit prime; only candidates with a short power walk go with it
  localparam logic [W-1:0] TOP_PRIME = 16'd65521;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [W-1:0] cfg_data;
  logic         start;
  logic         busy;
  logic [W-1:0] candidate;
  logic         done;
  logic         is_root;
  status_t      status;
  int           errors;
  int           outstanding;

  // no random gaps while this is set
  bit calm;

  primitive_root_tester #(.VALUE_WIDTH(W)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .candidate (candidate),
    .done      (done),
    .is_root   (is_root),
    .status    (status)
  );

  root_result_checker #(.VALUE_WIDTH(W)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .candidate   (candidate),
    .done        (done),
    .is_root     (is_root),
    .status      (status),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // random pause of the sender, roughly 7 times in a hundred
  task automatic maybe_pause();
    if (!calm && $urandom_range(99) < 7) begin
      start = 1'b0;
      repeat ($urandom_range(1, 25)) @(negedge clk);
    end
  endtask

  // one request; start stays high into the next request unless a pause comes
  task automatic send_candidate(input logic [W-1:0] value);
    maybe_pause();
    start     = 1'b1;
    candidate = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // modulus writes only when the block is idle: every result has come back
  task automatic set_modulus(input logic [W-1:0] value);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    maybe_pause();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    logic [W-1:0] mod_value;
    logic [W-1:0] value;
    int           pick;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    start     = 1'b0;
    candidate = '0;
    calm      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // modulus zero and one: too small wins over everything
    set_modulus(16'd0);
    send_candidate(16'd0);
    send_candidate(16'd5);
    set_modulus(16'd1);
    send_candidate(16'd1);
    // even composite, and a square of three right at the divisor bound
    set_modulus(16'd4);
    send_candidate(16'd3);
    set_modulus(16'd9);
    send_candidate(16'd2);
    // square of a prime: the divisor search runs all the way up
    // and not prime must win over an out of range candidate
    set_modulus(16'd63001);
    send_candidate(16'd0);
    set_modulus(16'hFFFF);
    send_candidate(16'hFFFF);
    // modulus two: the power range is empty, so one counts as a root
    set_modulus(16'd2);
    send_candidate(16'd1);
    send_candidate(16'd0);
    send_candidate(16'd2);
    send_candidate(16'hFFFF);
    set_modulus(16'd3);
    send_candidate(16'd1);
    send_candidate(16'd2);
    // small prime: a root, a non-root, one, p-1 and p itself
    set_modulus(16'd7);
    send_candidate(16'd3);
    send_candidate(16'd2);
    send_candidate(16'd1);
    send_candidate(16'd6);
    send_candidate(16'd7);
    // largest prime: long divisor search, short power walks only
    set_modulus(TOP_PRIME);
    send_candidate(16'd1);
    send_candidate(TOP_PRIME - 16'd1);
    send_candidate(TOP_PRIME);
    send_candidate(16'hFFFF);
    send_candidate(16'd0);
    // a mid-size prime, with ten and p-1 as candidates
    set_modulus(16'd1021);
    send_candidate(16'd10);
    send_candidate(16'd1020);

    // random phases; two of them run without any pause
    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 3 || phase == 4);
      pick = $urandom_range(99);
      if (pick < 30)
        mod_value = W'($urandom_range(2, 255) * $urandom_range(2, 255));
      else if (pick < 85)
        mod_value = W'($urandom_range(0, 211));
      else
        mod_value = TOP_PRIME;
      set_modulus(mod_value);
      repeat (10) begin
        if (mod_value == TOP_PRIME) begin
          // keep the power walk short with the big prime
          case ($urandom_range(3))
            0:       value = 16'd1;
            1:       value = TOP_PRIME - 16'd1;
            2:       value = W'($urandom_range(TOP_PRIME, 16'hFFFF));
            default: value = 16'd0;
          endcase
        end else if (mod_value >= 2 && mod_value < 256 && $urandom_range(99) < 80)
          value = W'($urandom_range(1, mod_value - 1));
        else
          value = W'($urandom_range(0, 16'hFFFF));
        send_candidate(value);
      end
    end
    calm  = 1'b0;
    start = 1'b0;

    // drain, then wait on for any stray strobes
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && outstanding == 0)
      $display("primitive_root_tester test passed");
    else
      $display("primitive_root_tester test failed");
    $finish;
  end

  // hard stop: reports a failure and ends the run
  initial begin
    #10_000_000;
    $display("primitive_root_tester test failed");
    $finish;
  end

endmodule
